>>> src/ffba_pkg.sv
// shared constants, types and state codes of the first-fit block allocator
package ffba_pkg;

  localparam int POOL_WORDS = 1024;
  localparam int WORD_BYTES = 8;
  localparam int WORD_SHIFT = $clog2(WORD_BYTES);
  localparam int ADDR_W     = $clog2(POOL_WORDS);
  localparam int PTR_W      = ADDR_W + 1;
  localparam int HDR_W      = PTR_W + 1;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_LARGEST = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  typedef struct packed {
    logic [PTR_W-1:0] nxt;
    logic             alloc;
  } hdr_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOAD,
    ST_EVAL,
    ST_NEXT,
    ST_SPLIT,
    ST_MARK,
    ST_FREE,
    ST_RESP
  } state_t;

endpackage

>>> src/first_fit_block_allocator_core.sv
// first-fit allocator over an implicit header list held in a block ram
//
// usage:
// - request channel: in_valid / in_stall with operation, request_bytes and
//   release_offset; a request is taken when in_valid is high and in_stall low
// - result channel: out_valid / out_stall with status, data_offset and
//   largest_bytes; exactly one result per request, in request order
// - config channel: cfg_valid / cfg_ready with cfg_data (pool length in
//   words); taken only while idle with no request offered; a write
//   re-initialises header 1 to span the whole pool
// - one request is worked at a time; in_stall is high while it runs
// - allocate and query walk the list through the eval and next states for
//   each visited block, reading its successor header from ram; a merge
//   writes the joined header and evaluates the block again; a split adds
//   one write of the new free header before the mark
// - free writes the released header when the offset is valid; a zero-size
//   allocate or an unused code goes straight to the result
// - after reset the block writes header 1 in the init state, pool of 1024 words
// - when the receiver stalls, the finished result sits in the output
//   register; the next request may be taken and waits there to deliver
module first_fit_block_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [13:0] request_bytes,
  input  logic [12:0] release_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [12:0] data_offset,
  output logic [13:0] largest_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int PW = ffba_pkg::PTR_W;
  localparam int AW = ffba_pkg::ADDR_W;

  // header ram
  ffba_pkg::hdr_t mem [ffba_pkg::POOL_WORDS];
  ffba_pkg::hdr_t rdata;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  ffba_pkg::hdr_t mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;

  ffba_pkg::state_t state, state_next;

  // control and walk registers
  logic [PW-1:0] pool_end, pool_end_next;
  logic [1:0]    op, op_next;
  logic [PW-1:0] need, need_next;
  logic [AW-1:0] rel_addr, rel_addr_next;
  logic [PW-1:0] h, h_next;
  logic [PW-1:0] best, best_next;
  ffba_pkg::hdr_t hcur, hcur_next;
  logic [PW-1:0] mark_nxt, mark_nxt_next;

  // pending result
  logic        res_status, res_status_next;
  logic [12:0] res_data, res_data_next;
  logic [13:0] res_largest, res_largest_next;

  // request decode
  logic [14:0]   req_sum;
  logic [14:0]   req_wide;
  logic [PW-1:0] req_words;
  logic [AW-1:0] rel_word;
  logic          rel_ok;
  logic [PW-1:0] cfg_clamped;

  // evaluation of the current header
  logic          nx_fwd;
  logic [PW-1:0] nx_c;
  logic [PW-1:0] span;
  logic          upd;
  logic [PW-1:0] best_new;
  logic          fit;
  logic          walk_done;
  logic          do_split;
  logic [PW-1:0] split_addr;
  logic [13:0]   found_data;
  logic [13:0]   largest_val;

  logic out_free;
  logic accept;
  logic cfg_wr;

  assign in_stall  = (state != ffba_pkg::ST_IDLE);
  // config waits while a request is offered so header 1 is never read and
  // rewritten at the same edge
  assign cfg_ready = (state == ffba_pkg::ST_IDLE) && !in_valid;
  assign accept    = in_valid && !in_stall;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;

  assign req_sum   = {1'b0, request_bytes} + 15'(ffba_pkg::WORD_BYTES - 1);
  assign req_wide  = req_sum >> ffba_pkg::WORD_SHIFT;
  // a request of a whole pool or more can never fit, so it saturates there
  assign req_words = (req_wide >= 15'(ffba_pkg::POOL_WORDS))
                     ? PW'(ffba_pkg::POOL_WORDS) : PW'(req_wide);
  assign rel_word  = AW'(release_offset >> ffba_pkg::WORD_SHIFT);
  // header must be past word 0 and inside the pool
  assign rel_ok    = (release_offset != 13'd0) && (rel_word >= AW'(2))
                     && ({1'b0, rel_word - AW'(1)} < pool_end);
  assign cfg_clamped = (cfg_data > 11'(ffba_pkg::POOL_WORDS))
                       ? PW'(ffba_pkg::POOL_WORDS) : PW'(cfg_data);

  // a backward link is treated as running to the pool end
  assign nx_fwd    = hcur.nxt > h;
  assign nx_c      = nx_fwd ? hcur.nxt : pool_end;
  assign span      = nx_c - h;
  assign upd       = !hcur.alloc && (best < span);
  assign best_new  = upd ? span : best;
  assign fit       = (op == ffba_pkg::OP_ALLOC) && upd && ((span - PW'(1)) >= need);
  assign walk_done = (h >= pool_end);
  assign do_split  = ({1'b0, hcur.nxt} - {1'b0, h}) > ({1'b0, need} + (PW+1)'(2));
  assign split_addr = h + need + PW'(1);
  assign found_data = 14'((14'(h) + 14'd1) << ffba_pkg::WORD_SHIFT);
  assign largest_val = (best >= PW'(1))
                       ? 14'(14'(best - PW'(1)) << ffba_pkg::WORD_SHIFT) : 14'd0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffba_pkg::ST_INIT: state_next = ffba_pkg::ST_IDLE;
      ffba_pkg::ST_IDLE: begin
        if (accept) begin
          case (operation)
            ffba_pkg::OP_ALLOC:
              state_next = (request_bytes == 14'd0) ? ffba_pkg::ST_RESP : ffba_pkg::ST_LOAD;
            ffba_pkg::OP_FREE:
              state_next = rel_ok ? ffba_pkg::ST_FREE : ffba_pkg::ST_RESP;
            ffba_pkg::OP_LARGEST: state_next = ffba_pkg::ST_LOAD;
            default: state_next = ffba_pkg::ST_RESP;
          endcase
        end
      end
      ffba_pkg::ST_LOAD: state_next = ffba_pkg::ST_EVAL;
      ffba_pkg::ST_EVAL: begin
        if (walk_done) begin
          state_next = ffba_pkg::ST_RESP;
        end else if (fit) begin
          state_next = do_split ? ffba_pkg::ST_SPLIT : ffba_pkg::ST_MARK;
        end else if (nx_fwd && (hcur.nxt < pool_end)) begin
          state_next = ffba_pkg::ST_NEXT;
        end
      end
      ffba_pkg::ST_NEXT:  state_next = ffba_pkg::ST_EVAL;
      ffba_pkg::ST_SPLIT: state_next = ffba_pkg::ST_MARK;
      ffba_pkg::ST_MARK:  state_next = ffba_pkg::ST_RESP;
      ffba_pkg::ST_FREE:  state_next = ffba_pkg::ST_RESP;
      ffba_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = ffba_pkg::ST_IDLE;
        end
      end
      default: state_next = ffba_pkg::ST_INIT;
    endcase
  end

  // ram controls and datapath
  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = AW'(1);
    mem_wdata        = '0;
    mem_re           = 1'b0;
    mem_raddr        = AW'(1);
    pool_end_next    = pool_end;
    op_next          = op;
    need_next        = need;
    rel_addr_next    = rel_addr;
    h_next           = h;
    best_next        = best;
    hcur_next        = hcur;
    mark_nxt_next    = mark_nxt;
    res_status_next  = res_status;
    res_data_next    = res_data;
    res_largest_next = res_largest;
    unique case (state)
      ffba_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '{nxt: pool_end, alloc: 1'b0};
      end
      ffba_pkg::ST_IDLE: begin
        if (cfg_wr) begin
          pool_end_next = cfg_clamped;
          mem_we        = 1'b1;
          mem_wdata     = '{nxt: cfg_clamped, alloc: 1'b0};
        end
        if (accept) begin
          op_next          = operation;
          need_next        = req_words;
          rel_addr_next    = rel_word - AW'(1);
          h_next           = PW'(1);
          best_next        = '0;
          res_status_next  = (operation == ffba_pkg::OP_ALLOC) && (request_bytes == 14'd0);
          res_data_next    = '0;
          res_largest_next = '0;
          // first header, or the header to release
          mem_re    = (operation == ffba_pkg::OP_ALLOC) || (operation == ffba_pkg::OP_LARGEST)
                      || ((operation == ffba_pkg::OP_FREE) && rel_ok);
          mem_raddr = (operation == ffba_pkg::OP_FREE) ? (rel_word - AW'(1)) : AW'(1);
        end
      end
      ffba_pkg::ST_LOAD: hcur_next = rdata;
      ffba_pkg::ST_EVAL: begin
        if (walk_done) begin
          if (op == ffba_pkg::OP_ALLOC) begin
            res_status_next = 1'b1;
          end else begin
            res_largest_next = largest_val;
          end
        end else if (fit) begin
          mark_nxt_next = do_split ? split_addr : hcur.nxt;
          res_data_next = found_data[12:0];
        end else if (nx_fwd && (hcur.nxt < pool_end)) begin
          best_next = best_new;
          mem_re    = 1'b1;
          mem_raddr = hcur.nxt[AW-1:0];
        end else begin
          best_next = best_new;
          h_next    = nx_c;
        end
      end
      ffba_pkg::ST_NEXT: begin
        if (!hcur.alloc && !rdata.alloc) begin
          // merge the free successor into this block
          mem_we    = 1'b1;
          mem_waddr = h[AW-1:0];
          mem_wdata = '{nxt: rdata.nxt, alloc: 1'b0};
          hcur_next = '{nxt: rdata.nxt, alloc: 1'b0};
        end else begin
          h_next    = hcur.nxt;
          hcur_next = rdata;
        end
      end
      ffba_pkg::ST_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = mark_nxt[AW-1:0];
        mem_wdata = '{nxt: hcur.nxt, alloc: 1'b0};
      end
      ffba_pkg::ST_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = h[AW-1:0];
        mem_wdata = '{nxt: mark_nxt, alloc: 1'b1};
      end
      ffba_pkg::ST_FREE: begin
        mem_we    = 1'b1;
        mem_waddr = rel_addr;
        mem_wdata = '{nxt: rdata.nxt, alloc: 1'b0};
      end
      ffba_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // header ram, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffba_pkg::ST_INIT;
      pool_end <= PW'(ffba_pkg::POOL_WORDS);
    end else begin
      state    <= state_next;
      pool_end <= pool_end_next;
    end
  end

  always_ff @(posedge clk) begin
    op          <= op_next;
    need        <= need_next;
    rel_addr    <= rel_addr_next;
    h           <= h_next;
    best        <= best_next;
    hcur        <= hcur_next;
    mark_nxt    <= mark_nxt_next;
    res_status  <= res_status_next;
    res_data    <= res_data_next;
    res_largest <= res_largest_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= (state == ffba_pkg::ST_RESP);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && (state == ffba_pkg::ST_RESP)) begin
      status        <= res_status;
      data_offset   <= res_data;
      largest_bytes <= res_largest;
    end
  end

endmodule

>>> src/ffba_checker.sv
// port-level checks of the first-fit allocator, bound to the top level
module ffba_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        status,
  input logic [12:0] data_offset,
  input logic [13:0] largest_bytes,
  input logic        cfg_ready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a failed allocate carries no offset and no query size
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (data_offset == 13'd0) && (largest_bytes == 14'd0))
    else $error("failure result carries data");

  // an allocate result with an offset carries no query size and no failure
  a_alloc_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && (data_offset != 13'd0) |-> (largest_bytes == 14'd0) && !status)
    else $error("allocate result mixes fields");

  // an accepted request keeps the block busy next cycle, config closed
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("block free right after accepting a request");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (.*);
